// ===== sv/sphd_pkg.sv =====
// package for the spead packet header offset decoder: payload types and constants
`timescale 1ns / 1ps
package sphd_pkg;
    localparam int FRACTION_BITS = 24;
    localparam int MAX_STREAMS = 1024;

    localparam logic [62:0] M63 = {63{1'b1}};
    localparam logic [62:0] ID_TIMESTAMP = 63'h1600;
    localparam logic [62:0] ID_CHANNEL = 63'h4103;
    localparam logic [62:0] ID_HEAP_CNT = 63'd1;
    localparam logic [62:0] ID_HEAP_LEN = 63'd2;
    localparam logic [62:0] ID_PAY_OFF = 63'd3;
    localparam logic [62:0] ID_PAY_LEN = 63'd4;
    localparam logic [62:0] ID_STREAM_CTRL = 63'd6;

    localparam logic [2:0] ST_OK = 3'd0;
    localparam logic [2:0] ST_NOT_DATA = 3'd1;
    localparam logic [2:0] ST_RANGE = 3'd2;
    localparam logic [2:0] ST_BEFORE = 3'd3;
    localparam logic [2:0] ST_STOP = 3'd4;

    localparam logic [2:0] REG_START = 3'd0;
    localparam logic [2:0] REG_RATIO = 3'd1;
    localparam logic [2:0] REG_HEAPLEN = 3'd2;
    localparam logic [2:0] REG_FIRSTCH = 3'd3;
    localparam logic [2:0] REG_CPS = 3'd4;
    localparam logic [2:0] REG_SCOUNT = 3'd5;

    typedef struct packed {
        logic [63:0] word;
        logic        first_word;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  status;
        logic [62:0] buf_offset;
        logic [47:0] pay_size;
        logic [9:0]  stream_index;
        logic        upper_subband;
    } t_out_item;
endpackage

// ===== sv/spead_packet_header_offset_decoder_top.sv =====
// top level: pointer parser, config registers and output register
//  channel | valid   | stall   | payload
//  in      | i_valid | o_stall | i_item (word, first_word)
//  out     | o_valid | i_stall | o_item (status, buf_offset, ...)
//  cfg     | psel/penable/pwrite, paddr 6 bits, pwdata 64 bits
// pointer words are taken while o_stall is low; the last pointer starts the sequencer
// in the next cycle; input stalls until the result is loaded, for a reject decided
// at once, a range or start reject after the 48-step divider, or an accepted packet
// a finished result waits in the sequencer while the output item is stalled
// synchronous active-low reset clears control state and loads register defaults
`timescale 1ns / 1ps
module spead_packet_header_offset_decoder_top #(
    parameter int FRACTION_BITS = sphd_pkg::FRACTION_BITS,
    parameter int MAX_STREAMS = sphd_pkg::MAX_STREAMS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  sphd_pkg::t_in_item  i_item,
    output logic                o_valid,
    input  logic                i_stall,
    output sphd_pkg::t_out_item o_item,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [5:0]          paddr,
    input  logic [63:0]         pwdata,
    output logic [63:0]         prdata,
    output logic                pready
);
    logic [47:0] r_start;
    logic [31:0] r_ratio;
    logic [47:0] r_exp_len;
    logic [11:0] r_first_ch;
    logic [10:0] r_cps;
    logic [10:0] r_scount;

    logic [15:0] r_pidx, r_ptot, r_first_reg;
    logic [6:0]  r_aw;
    logic [4:0]  r_marks;
    logic [47:0] r_hlen, r_poff, r_plen, r_ts, r_chan;
    logic        r_stop;
    logic        r_busy;
    logic        r_go;
    logic        r_ovalid;
    sphd_pkg::t_out_item r_out;

    logic        w_acc, w_done, w_hold, w_move;
    logic [2:0]  w_reg;
    logic [62:0] w_id, w_vmask, w_imask;
    logic [47:0] w_val;
    logic        w_imm, w_special;
    logic [7:0]  w_bytes;
    logic        w_is_data;
    sphd_pkg::t_out_item w_res;

    assign pready = 1'b1;
    assign w_reg = paddr[5:3];
    assign o_stall = r_busy || r_go;
    assign w_acc = i_valid && !o_stall;
    assign w_hold = r_ovalid && i_stall;
    assign w_move = w_done && !w_hold;
    assign o_valid = r_ovalid;
    assign o_item = r_out;

    always_comb begin
        unique case (w_reg)
            sphd_pkg::REG_START:   prdata = {16'd0, r_start};
            sphd_pkg::REG_RATIO:   prdata = {32'd0, r_ratio};
            sphd_pkg::REG_HEAPLEN: prdata = {16'd0, r_exp_len};
            sphd_pkg::REG_FIRSTCH: prdata = {52'd0, r_first_ch};
            sphd_pkg::REG_CPS:     prdata = {53'd0, r_cps};
            sphd_pkg::REG_SCOUNT:  prdata = {53'd0, r_scount};
            default:               prdata = '0;
        endcase
    end

    always_comb begin
        w_bytes = i_item.word[39:32];
        w_vmask = (r_aw == 7'd0) ? '0 : ((63'd1 << r_aw) - 63'd1);
        w_imask = (r_aw >= 7'd63) ? '0 : ((63'd1 << (7'd63 - r_aw)) - 63'd1);
        w_id = (i_item.word[62:0] >> r_aw) & w_imask;
        w_val = i_item.word[47:0] & w_vmask[47:0];
        w_imm = i_item.word[63];
        w_special = w_imm && (w_id == sphd_pkg::ID_HEAP_CNT || w_id == sphd_pkg::ID_HEAP_LEN
            || w_id == sphd_pkg::ID_PAY_OFF || w_id == sphd_pkg::ID_PAY_LEN
            || w_id == sphd_pkg::ID_TIMESTAMP || w_id == sphd_pkg::ID_CHANNEL);
        w_is_data = (r_ptot - r_first_reg) == 16'd1 && r_marks[0] && r_marks[1]
            && r_hlen == r_exp_len;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= '0;
            r_ratio <= 32'd16777216;
            r_exp_len <= 48'd524288;
            r_first_ch <= '0;
            r_cps <= 11'd1;
            r_scount <= 11'd1;
            r_pidx <= '0; r_ptot <= '0; r_first_reg <= '0; r_aw <= '0;
            r_marks <= '0; r_stop <= 1'b0;
            r_hlen <= '0; r_poff <= '0; r_plen <= '0; r_ts <= '0; r_chan <= '0;
            r_busy <= 1'b0; r_go <= 1'b0; r_ovalid <= 1'b0;
        end else begin
            if (psel && penable && pwrite) begin
                unique case (w_reg)
                    sphd_pkg::REG_START:   r_start <= pwdata[47:0];
                    sphd_pkg::REG_RATIO:   r_ratio <= pwdata[31:0];
                    sphd_pkg::REG_HEAPLEN: r_exp_len <= pwdata[47:0];
                    sphd_pkg::REG_FIRSTCH: r_first_ch <= pwdata[11:0];
                    sphd_pkg::REG_CPS:     r_cps <= pwdata[10:0];
                    sphd_pkg::REG_SCOUNT:  r_scount <= pwdata[10:0];
                    default: ;
                endcase
            end
            r_go <= w_acc && (i_item.first_word ? (i_item.word[15:0] == 16'd0)
                                                : (r_pidx < r_ptot && r_pidx + 16'd1 == r_ptot));
            if (w_acc) begin
                if (i_item.first_word) begin
                    r_aw <= (w_bytes <= 8'd7) ? {w_bytes[3:0], 3'd0} : 7'd63;
                    r_ptot <= i_item.word[15:0];
                    r_first_reg <= i_item.word[15:0];
                    r_pidx <= '0;
                    r_marks <= '0; r_stop <= 1'b0;
                    r_hlen <= '0; r_poff <= '0; r_plen <= '0; r_ts <= '0; r_chan <= '0;
                end else if (r_pidx < r_ptot) begin
                    if (w_imm) begin
                        if (w_id == sphd_pkg::ID_HEAP_LEN) begin
                            r_hlen <= w_val; r_marks[0] <= 1'b1;
                        end
                        if (w_id == sphd_pkg::ID_PAY_OFF) begin
                            r_poff <= w_val; r_marks[1] <= 1'b1;
                        end
                        if (w_id == sphd_pkg::ID_PAY_LEN) begin
                            r_plen <= w_val; r_marks[2] <= 1'b1;
                        end
                        if (w_id == sphd_pkg::ID_TIMESTAMP) begin
                            r_ts <= w_val; r_marks[3] <= 1'b1;
                        end
                        if (w_id == sphd_pkg::ID_CHANNEL) begin
                            r_chan <= w_val; r_marks[4] <= 1'b1;
                        end
                        if (w_id == sphd_pkg::ID_STREAM_CTRL
                                && (i_item.word[62:0] & w_vmask) == 63'd2) r_stop <= 1'b1;
                    end
                    if (!w_special && r_pidx < r_first_reg) r_first_reg <= r_pidx;
                    r_pidx <= r_pidx + 16'd1;
                end
            end
            if (r_go) begin
                r_busy <= 1'b1;
            end else if (w_move) begin
                r_busy <= 1'b0;
            end
            if (w_move) begin
                r_ovalid <= 1'b1;
                r_out <= w_res;
            end else if (r_ovalid && !i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    sphd_calc #(
        .FRACTION_BITS(FRACTION_BITS),
        .MAX_STREAMS(MAX_STREAMS)
    ) u_calc (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_start(r_go),
        .i_hold(w_hold),
        .i_is_data(w_is_data),
        .i_stop_seen(r_stop),
        .i_has_chan(r_marks[4]),
        .i_has_ts(r_marks[3]),
        .i_channel(r_chan),
        .i_timestamp(r_ts),
        .i_heap_len(r_hlen),
        .i_pay_off(r_poff),
        .i_pay_len(r_plen),
        .i_start_sample(r_start),
        .i_ratio(r_ratio),
        .i_first_channel(r_first_ch),
        .i_cps(r_cps),
        .i_scount(r_scount),
        .o_done(w_done),
        .o_result(w_res)
    );

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy || r_go) |-> !w_acc) else $error("item taken while busy");
    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done |-> r_busy) else $error("result without packet");
    a_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pidx <= r_ptot) else $error("pointer index overrun");
endmodule

// ===== sv/sphd_calc.sv =====
// offset sequencer: stream division, scaled timestamp and saturating sums
`timescale 1ns / 1ps
module sphd_calc #(
    parameter int FRACTION_BITS = sphd_pkg::FRACTION_BITS,
    parameter int MAX_STREAMS = sphd_pkg::MAX_STREAMS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic                i_hold,
    input  logic                i_is_data,
    input  logic                i_stop_seen,
    input  logic                i_has_chan,
    input  logic                i_has_ts,
    input  logic [47:0]         i_channel,
    input  logic [47:0]         i_timestamp,
    input  logic [47:0]         i_heap_len,
    input  logic [47:0]         i_pay_off,
    input  logic [47:0]         i_pay_len,
    input  logic [47:0]         i_start_sample,
    input  logic [31:0]         i_ratio,
    input  logic [11:0]         i_first_channel,
    input  logic [10:0]         i_cps,
    input  logic [10:0]         i_scount,
    output logic                o_done,
    output sphd_pkg::t_out_item o_result
);
    localparam int SW = $clog2(MAX_STREAMS + 1);
    localparam logic [SW-1:0] MAXS = SW'(MAX_STREAMS);

    typedef enum logic [2:0] {
        S_IDLE, S_DIV, S_CHECK, S_MUL_LO, S_MUL_HI, S_ADD_SH, S_ADD_POFF, S_DONE
    } t_state;

    t_state      r_state;
    logic [47:0] r_rem;
    logic [47:0] r_quo;
    logic [5:0]  r_cnt;
    logic [10:0] r_div;
    logic [47:0] r_obs;
    logic [63:0] r_plo;
    logic [63:0] r_acc;
    logic        r_sat;
    logic [SW-1:0] r_cnt_lim;
    sphd_pkg::t_out_item r_res;

    logic [48:0] w_trial;
    logic [47:0] w_shrem;
    logic [63:0] w_mul;
    logic [31:0] w_mul_a;
    logic [63:0] w_sum;
    logic [63:0] w_addend;
    logic [63:0] w_phi_sh;
    logic [SW+47:0] w_sprod;
    logic        w_chan_low;

    always_comb begin
        w_shrem = {r_rem[46:0], r_quo[47]};
        w_trial = {1'b0, w_shrem} - {38'd0, r_div};
        w_mul_a = (r_state == S_MUL_LO) ? r_obs[31:0] : {16'd0, r_obs[47:32]};
        w_mul = {32'd0, w_mul_a} * {32'd0, i_ratio};
        w_phi_sh = w_mul << (32 - FRACTION_BITS);
        // stream index is below the stream limit here
        w_sprod = r_quo[SW-1:0] * i_heap_len;
        unique case (r_state)
            S_ADD_SH:   w_addend = {{(16 - SW){1'b0}}, w_sprod};
            default:    w_addend = {16'd0, i_pay_off};
        endcase
        w_sum = r_acc + w_addend;
        w_chan_low = !i_has_chan || (i_channel < {36'd0, i_first_channel});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_res.pay_size <= i_pay_len;
                        r_res.buf_offset <= '0;
                        r_res.stream_index <= '0;
                        r_res.upper_subband <= 1'b0;
                        r_res.status <= !i_is_data ? (i_stop_seen ? sphd_pkg::ST_STOP
                                                                  : sphd_pkg::ST_NOT_DATA)
                                      : (w_chan_low ? sphd_pkg::ST_RANGE : sphd_pkg::ST_OK);
                        r_cnt_lim <= (32'(i_scount) > 32'(MAX_STREAMS)) ? MAXS
                                                                         : SW'(i_scount);
                        r_div <= (i_cps == 11'd0) ? 11'd1 : i_cps;
                        r_rem <= '0;
                        r_quo <= i_channel - {36'd0, i_first_channel};
                        r_cnt <= 6'd0;
                        r_obs <= i_timestamp - i_start_sample;
                        r_sat <= 1'b0;
                        r_state <= (!i_is_data || w_chan_low) ? S_DONE : S_DIV;
                    end
                end
                S_DIV: begin
                    // restoring division, one quotient bit per cycle
                    if (!w_trial[48]) begin
                        r_rem <= w_trial[47:0];
                        r_quo <= {r_quo[46:0], 1'b1};
                    end else begin
                        r_rem <= w_shrem;
                        r_quo <= {r_quo[46:0], 1'b0};
                    end
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == 6'd47) r_state <= S_CHECK;
                end
                S_CHECK: begin
                    if (r_quo >= 48'(r_cnt_lim)) begin
                        r_res.status <= sphd_pkg::ST_RANGE;
                        r_state <= S_DONE;
                    end else if (!i_has_ts || i_timestamp < i_start_sample) begin
                        r_res.status <= sphd_pkg::ST_BEFORE;
                        r_state <= S_DONE;
                    end else begin
                        r_res.stream_index <= r_quo[9:0];
                        r_res.upper_subband <= r_quo >= 48'(r_cnt_lim >> 1);
                        r_state <= S_MUL_LO;
                    end
                end
                S_MUL_LO: begin
                    r_plo <= w_mul;
                    r_state <= S_MUL_HI;
                end
                S_MUL_HI: begin
                    if ((w_mul >> (31 + FRACTION_BITS)) != 64'd0) begin
                        r_acc <= {1'b0, sphd_pkg::M63};
                    end else begin
                        r_acc <= w_phi_sh + (r_plo >> FRACTION_BITS);
                    end
                    r_state <= S_ADD_SH;
                end
                S_ADD_SH: begin
                    if (r_acc > {1'b0, sphd_pkg::M63}) r_acc <= {1'b0, sphd_pkg::M63};
                    else if (w_sum > {1'b0, sphd_pkg::M63}) r_acc <= {1'b0, sphd_pkg::M63};
                    else r_acc <= w_sum;
                    r_state <= S_ADD_POFF;
                end
                S_ADD_POFF: begin
                    r_res.buf_offset <= (w_sum > {1'b0, sphd_pkg::M63}) ? sphd_pkg::M63
                                                                       : w_sum[62:0];
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (!i_hold) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_done = (r_state == S_DONE);
    assign o_result = r_res;

    a_div_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_cnt <= 6'd47)) else $error("div overrun");
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && !i_hold) |=> (r_state == S_IDLE)) else $error("done held");
    a_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ADD_POFF) |-> (r_acc <= {1'b0, sphd_pkg::M63}))
        else $error("acc overflow");
endmodule

// ===== bench/tb_spead_packet_header_offset_decoder_top.sv =====
// testbench for the spead packet header offset decoder: random and directed packets vs a predictor
`timescale 1ns / 1ps
module tb_spead_packet_header_offset_decoder_top;
    localparam int WATCHDOG_LIMIT = 20000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    sphd_pkg::t_in_item  i_item = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    sphd_pkg::t_out_item o_item;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [5:0]  paddr = '0;
    logic [63:0] pwdata = '0;
    logic [63:0] prdata;
    logic        pready;

    spead_packet_header_offset_decoder_top u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_item(i_item), .o_valid(o_valid), .i_stall(i_stall), .o_item(o_item),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // predictor state
    logic [47:0] cfg_start = '0;
    logic [31:0] cfg_ratio = 32'd16777216;
    logic [47:0] cfg_heaplen = 48'd524288;
    logic [11:0] cfg_firstch = '0;
    logic [10:0] cfg_cps = 11'd1;
    logic [10:0] cfg_scount = 11'd1;

    logic [15:0] ptr_idx = '0, ptr_total = '0, first_reg = '0;
    int          addr_bits = 0;
    logic [4:0]  marks = '0;
    logic [47:0] heaplen_v = '0, payoff_v = '0, paylen_v = '0, ts_v = '0, chan_v = '0;
    logic        stop_v = 1'b0;

    sphd_pkg::t_in_item  pending_items[$];
    sphd_pkg::t_out_item decoded_results[$];

    int send_idle_pct = 0, recv_idle_pct = 0;
    bit hold_sender = 1'b0;
    int mismatches = 0;
    int watchdog = 0;
    bit timed_out = 1'b0;

    function automatic logic [62:0] sat_sum(logic [62:0] a, logic [62:0] b);
        logic [63:0] s;
        s = {1'b0, a} + {1'b0, b};
        return (s > {1'b0, sphd_pkg::M63}) ? sphd_pkg::M63 : s[62:0];
    endfunction

    function automatic sphd_pkg::t_out_item packet_verdict();
        sphd_pkg::t_out_item r;
        logic [15:0] cps, cnt;
        logic [47:0] obs, s;
        logic [95:0] plo, phi;
        logic [127:0] off;
        logic [62:0] o;
        bit data, ok;
        r = '0;
        data = (ptr_total - first_reg) == 16'd1 && marks[0] && heaplen_v == cfg_heaplen
               && marks[1];
        if (!data) begin
            r.status = stop_v ? sphd_pkg::ST_STOP : sphd_pkg::ST_NOT_DATA;
        end else begin
            cps = (cfg_cps == 0) ? 16'd1 : 16'(cfg_cps);
            cnt = (cfg_scount > sphd_pkg::MAX_STREAMS) ? 16'(sphd_pkg::MAX_STREAMS)
                                                      : 16'(cfg_scount);
            s = '0;
            ok = marks[4] && chan_v >= 48'(cfg_firstch);
            if (ok) begin
                s = (chan_v - 48'(cfg_firstch)) / 48'(cps);
                ok = s < 48'(cnt);
            end
            if (!ok) begin
                r.status = sphd_pkg::ST_RANGE;
            end else if (!marks[3] || ts_v < cfg_start) begin
                r.status = sphd_pkg::ST_BEFORE;
            end else begin
                obs = ts_v - cfg_start;
                plo = 96'(obs[31:0]) * 96'(cfg_ratio);
                phi = 96'(obs[47:32]) * 96'(cfg_ratio);
                if ((phi >> (31 + sphd_pkg::FRACTION_BITS)) != 0) begin
                    o = sphd_pkg::M63;
                end else begin
                    off = (128'(phi) << (32 - sphd_pkg::FRACTION_BITS))
                          + 128'(plo >> sphd_pkg::FRACTION_BITS);
                    o = (off > 128'(sphd_pkg::M63)) ? sphd_pkg::M63 : off[62:0];
                end
                o = sat_sum(o, 63'(96'(s) * 96'(heaplen_v)));
                o = sat_sum(o, 63'(payoff_v));
                r.status = sphd_pkg::ST_OK;
                r.buf_offset = o;
                r.stream_index = s[9:0];
                r.upper_subband = s >= 48'(cnt / 2);
            end
        end
        r.pay_size = paylen_v;
        return r;
    endfunction

    task automatic decode_word(sphd_pkg::t_in_item it);
        logic [63:0] vmask, imask, id;
        logic [47:0] v;
        bit special;
        if (it.first_word) begin
            addr_bits = (it.word[39:32] <= 8'd7) ? 8 * int'(it.word[39:32]) : 63;
            ptr_total = it.word[15:0];
            ptr_idx = '0;
            marks = '0;
            {heaplen_v, payoff_v, paylen_v, ts_v, chan_v} = '0;
            first_reg = ptr_total;
            stop_v = 1'b0;
            if (ptr_total == 0) decoded_results.push_back(packet_verdict());
        end else if (ptr_idx < ptr_total) begin
            vmask = (addr_bits == 0) ? 64'd0 : ((64'd1 << addr_bits) - 1);
            imask = (addr_bits >= 63) ? 64'd0 : ((64'd1 << (63 - addr_bits)) - 1);
            id = (it.word >> addr_bits) & imask;
            v = 48'(it.word & vmask);
            special = 1'b0;
            if (it.word[63]) begin
                special = 1'b1;
                if (id == 64'(sphd_pkg::ID_HEAP_CNT)) begin
                end else if (id == 64'(sphd_pkg::ID_HEAP_LEN)) begin
                    heaplen_v = v; marks[0] = 1'b1;
                end else if (id == 64'(sphd_pkg::ID_PAY_OFF)) begin
                    payoff_v = v; marks[1] = 1'b1;
                end else if (id == 64'(sphd_pkg::ID_PAY_LEN)) begin
                    paylen_v = v; marks[2] = 1'b1;
                end else if (id == 64'(sphd_pkg::ID_TIMESTAMP)) begin
                    ts_v = v; marks[3] = 1'b1;
                end else if (id == 64'(sphd_pkg::ID_CHANNEL)) begin
                    chan_v = v; marks[4] = 1'b1;
                end else begin
                    special = 1'b0;
                end
                if (id == 64'(sphd_pkg::ID_STREAM_CTRL) && (it.word & vmask) == 64'd2)
                    stop_v = 1'b1;
            end
            if (!special && ptr_idx < first_reg) first_reg = ptr_idx;
            ptr_idx++;
            if (ptr_idx == ptr_total) decoded_results.push_back(packet_verdict());
        end
    endtask

    // driver
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                decode_word(i_item);
                void'(pending_items.pop_front());
            end
            if (!(i_valid && o_stall)) begin
                if (pending_items.size() > 0 && !hold_sender
                    && $urandom_range(99) >= send_idle_pct) begin
                    i_valid <= 1'b1;
                    i_item <= pending_items[0];
                end else begin
                    i_valid <= 1'b0;
                end
            end
            i_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) watchdog <= 0;
            else watchdog <= watchdog + 1;
            if (o_valid && !i_stall) begin
                if (decoded_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected result %p", o_item);
                end else begin
                    if (o_item !== decoded_results[0]) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected %p actual %p",
                                     decoded_results[0], o_item);
                    end
                    void'(decoded_results.pop_front());
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (watchdog >= WATCHDOG_LIMIT && !timed_out) begin
            timed_out = 1'b1;
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic reg_write(logic [2:0] idx, logic [63:0] val);
        @(posedge i_clk);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
        paddr <= 6'(idx) << 3; pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            sphd_pkg::REG_START:   cfg_start = val[47:0];
            sphd_pkg::REG_RATIO:   cfg_ratio = val[31:0];
            sphd_pkg::REG_HEAPLEN: cfg_heaplen = val[47:0];
            sphd_pkg::REG_FIRSTCH: cfg_firstch = val[11:0];
            sphd_pkg::REG_CPS:     cfg_cps = val[10:0];
            sphd_pkg::REG_SCOUNT:  cfg_scount = val[10:0];
            default: ;
        endcase
    endtask

    task automatic drain();
        wait (pending_items.size() == 0 && !i_valid && decoded_results.size() == 0);
        repeat (80) @(posedge i_clk);
    endtask

    function automatic logic [63:0] imm_ptr(int ab, logic [62:0] id, logic [47:0] v);
        logic [63:0] w;
        w = (ab >= 63) ? 64'd0 : (64'(id) << ab);
        w = w | (64'(v) & ((ab == 0) ? 64'd0 : ((64'd1 << ab) - 1)));
        return {1'b1, w[62:0]};
    endfunction

    task automatic push_word(logic [63:0] w, bit f);
        sphd_pkg::t_in_item it;
        it.word = w;
        it.first_word = f;
        pending_items.push_back(it);
    endtask

    // one packet; kind 0 data-like, 1 random pointers, 2 stop packet
    task automatic push_packet(int kind);
        int nb, ab, n, slot;
        logic [62:0] ids[6];
        nb = ($urandom_range(9) == 0) ? $urandom_range(255) : (($urandom_range(1)) ? 6 : 5);
        ab = (nb <= 7) ? nb * 8 : 63;
        ids = '{sphd_pkg::ID_HEAP_CNT, sphd_pkg::ID_HEAP_LEN, sphd_pkg::ID_PAY_OFF,
                sphd_pkg::ID_PAY_LEN, sphd_pkg::ID_TIMESTAMP, sphd_pkg::ID_CHANNEL};
        n = (kind == 1) ? $urandom_range(6) : 7;
        push_word({24'($urandom), 8'(nb), 16'($urandom), 16'(n)}, 1'b1);
        if (kind == 1) begin
            repeat (n) push_word({$urandom, $urandom}, 1'b0);
        end else begin
            slot = $urandom_range(5);
            for (int k = 0; k < 6; k++) begin
                logic [47:0] v;
                v = 48'({$urandom, $urandom});
                if (k == 1) v = ($urandom_range(7) != 0) ? cfg_heaplen : v;
                if (k == 2) v = $urandom_range(1) ? 48'($urandom) : v;
                if (k == 4) v = cfg_start + 48'($urandom_range(3) == 0 ? {$urandom, 16'h0}
                                                 : $urandom) - 48'($urandom_range(1));
                if (k == 5) v = 48'(cfg_firstch) + 48'($urandom_range(2100))
                                - 48'($urandom_range(3) == 0 ? 5 : 0);
                if (kind == 2 && k == slot)
                    push_word(imm_ptr(ab, sphd_pkg::ID_STREAM_CTRL, 48'd2), 1'b0);
                else if ($urandom_range(15) == 0)
                    push_word({$urandom, $urandom}, 1'b0);
                else
                    push_word(imm_ptr(ab, ids[k], v), 1'b0);
            end
            push_word({1'b0, 31'($urandom), $urandom}, 1'b0);
        end
        if ($urandom_range(19) == 0) push_word({$urandom, $urandom}, 1'b0);
    endtask

    task automatic random_phase(int count);
        int r;
        repeat (count) begin
            r = $urandom_range(9);
            push_packet(r < 7 ? 0 : (r < 9 ? 1 : 2));
        end
    endtask

    task automatic random_config();
        reg_write(sphd_pkg::REG_START, $urandom_range(1) ? 64'd0 : {$urandom, $urandom});
        reg_write(sphd_pkg::REG_RATIO,
                  $urandom_range(3) == 0 ? 64'hFFFF_FFFF : 64'($urandom));
        reg_write(sphd_pkg::REG_HEAPLEN, {$urandom, $urandom});
        reg_write(sphd_pkg::REG_FIRSTCH, 64'($urandom_range(4095)));
        reg_write(sphd_pkg::REG_CPS, 64'($urandom_range(2047)));
        reg_write(sphd_pkg::REG_SCOUNT, 64'($urandom_range(2047)));
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        send_idle_pct = 38; recv_idle_pct = 58;
        // directed: empty packet, default config packets, stray words, header mid-packet
        push_word({$urandom, $urandom} & 64'hFFFF_FFFF_FFFF_0000, 1'b1);
        push_word(64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
        push_word(64'h0, 1'b0);
        push_word(64'h0000_0006_0000_0003, 1'b1);
        push_word(imm_ptr(48, sphd_pkg::ID_HEAP_LEN, 48'd1), 1'b0);
        push_word(64'h0000_0006_0000_0002, 1'b1);
        push_word(imm_ptr(48, sphd_pkg::ID_STREAM_CTRL, 48'd2), 1'b0);
        push_word(64'd5, 1'b0);
        push_word(64'h0000_00FF_0000_0001, 1'b1);
        push_word(64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
        repeat (3) push_packet(0);
        push_packet(2);
        drain();
        reg_write(sphd_pkg::REG_START, 64'hFFFF_FFFF_FFFF);
        reg_write(sphd_pkg::REG_RATIO, 64'hFFFF_FFFF);
        reg_write(sphd_pkg::REG_HEAPLEN, 64'hFFFF_FFFF_FFFF);
        reg_write(sphd_pkg::REG_FIRSTCH, 64'd4095);
        reg_write(sphd_pkg::REG_CPS, 64'd0);
        reg_write(sphd_pkg::REG_SCOUNT, 64'd2047);
        repeat (4) push_packet(0);
        drain();
        reg_write(sphd_pkg::REG_START, 64'd0);
        reg_write(sphd_pkg::REG_RATIO, 64'hFFFF_FFFF);
        reg_write(sphd_pkg::REG_HEAPLEN, 64'd0);
        reg_write(sphd_pkg::REG_FIRSTCH, 64'd0);
        reg_write(sphd_pkg::REG_CPS, 64'd1024);
        reg_write(sphd_pkg::REG_SCOUNT, 64'd1);
        repeat (4) push_packet(0);
        drain();

        random_config();
        random_phase(45);
        wait (pending_items.size() < 20);
        hold_sender = 1'b1;
        wait (!i_valid || !o_stall);
        @(posedge i_clk);
        wait (decoded_results.size() == 0);
        hold_sender = 1'b0;
        drain();
        send_idle_pct = 58; recv_idle_pct = 38;
        random_config();
        random_phase(45);
        drain();
        send_idle_pct = 0; recv_idle_pct = 0;
        random_config();
        random_phase(45);
        drain();
        reg_write(sphd_pkg::REG_START, 64'd0);
        reg_write(sphd_pkg::REG_RATIO, 64'd16777216);
        reg_write(sphd_pkg::REG_HEAPLEN, 64'd524288);
        reg_write(sphd_pkg::REG_FIRSTCH, 64'd0);
        reg_write(sphd_pkg::REG_CPS, 64'd4);
        reg_write(sphd_pkg::REG_SCOUNT, 64'd1024);
        random_phase(20);
        drain();

        if (mismatches == 0 && decoded_results.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
